/* rtl/a4la_pkg.sv */
// ----------------------------------------------------------------------------
// a4la_pkg
// shared types and constants of the 4-bit adpcm look-ahead encoder
// ----------------------------------------------------------------------------
package a4la_pkg;

  // default look-ahead depth in samples
  localparam int A4LA_LOOKAHEAD_DEF = 2;

  localparam int SAMPLE_W = 8;
  localparam int CODE_W   = 4;
  localparam int STEP_W   = 4;
  localparam int ERR_W    = 18;

  localparam logic [STEP_W-1:0] STEP_RESET = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MAX   = 4'd8;
  localparam logic [2:0]        MAG_DOUBLE = 3'd5;
  localparam logic [CODE_W-1:0] CODE_MAX   = 4'hf;

  // decoder state carried along one search path
  typedef struct packed {
    logic [SAMPLE_W-1:0] pred;
    logic [STEP_W-1:0]   step;
    logic [ERR_W-1:0]    err;
  } a4la_dec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RAW,
    ST_SEARCH,
    ST_EMIT
  } a4la_state_t;

endpackage

/* rtl/a4la_node_unit.sv */
// ----------------------------------------------------------------------------
// a4la_node_unit
// shared decoder step: applies one code to a decoder state and adds the
// squared error against the target sample
// ----------------------------------------------------------------------------
module a4la_node_unit import a4la_pkg::*; (
  input  a4la_dec_t           cur,
  input  logic [CODE_W-1:0]   code,
  input  logic [SAMPLE_W-1:0] target,
  output a4la_dec_t           nxt
);

  logic [2:0]          mag;
  logic [6:0]          delta;
  logic [8:0]          sum;
  logic [SAMPLE_W-1:0] p_new;
  logic [STEP_W-1:0]   s_new;
  logic [SAMPLE_W-1:0] diff;
  logic [15:0]         sq;

  // delta = magnitude * step + step / 2
  assign mag   = code[2:0];
  assign delta = 7'({4'b0, mag} * {3'b0, cur.step}) + {4'b0, cur.step[3:1]};
  assign sum   = {1'b0, cur.pred} + {2'b0, delta};

  // saturating prediction update
  always_comb begin
    if (code[3]) begin
      p_new = sum[8] ? 8'hff : sum[7:0];
    end else begin
      p_new = ({1'b0, delta} > cur.pred) ? 8'h00 : (cur.pred - {1'b0, delta});
    end
  end

  // step adaptation, both tests on the incoming step
  always_comb begin
    s_new = cur.step;
    if (mag == 3'd0 && cur.step > STEP_RESET) begin
      s_new = {1'b0, cur.step[3:1]};
    end
    if (mag >= MAG_DOUBLE && cur.step < STEP_MAX) begin
      s_new = {cur.step[2:0], 1'b0};
    end
  end

  // squared error accumulation
  assign diff = (p_new > target) ? (p_new - target) : (target - p_new);
  assign sq   = {8'b0, diff} * {8'b0, diff};

  assign nxt.pred = p_new;
  assign nxt.step = s_new;
  assign nxt.err  = cur.err + {2'b0, sq};

endmodule

/* rtl/adpcm4_lookahead_encoder.sv */
// ----------------------------------------------------------------------------
// adpcm4_lookahead_encoder
// 4-bit adpcm encoder with exhaustive depth-first code search over a group
// of LOOKAHEAD samples, one decoder step per cycle
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, in_sample, in_first        | in
//  result  | out_valid, out_stall, out_value, out_is_raw,   | out
//          | out_group_error, out_last                      |
//
//  a sample that completes a group holds the input for the search over the
//  code tree, one node per cycle through the shared decoder unit, and for
//  the emit of the chosen codes. a seed holds the input while it goes out
//  raw through ST_RAW; a buffered or ignored sample is taken in ST_IDLE.
//  codes go out through one output register; out_stall holds it and the
//  emit sequence. reset is synchronous, active low; the buffer needs none.
// ----------------------------------------------------------------------------
module adpcm4_lookahead_encoder import a4la_pkg::*; #(
  parameter int LOOKAHEAD = A4LA_LOOKAHEAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_first,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_value,
  output logic                out_is_raw,
  output logic [ERR_W-1:0]    out_group_error,
  output logic                out_last
);

  localparam int IW  = (LOOKAHEAD > 1) ? $clog2(LOOKAHEAD) : 1;
  localparam int CBW = CODE_W * LOOKAHEAD;
  localparam logic [IW-1:0] LV_LAST = IW'(LOOKAHEAD - 1);

  a4la_state_t         state_r, state_nxt;
  logic [SAMPLE_W-1:0] pred_r, pred_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                seeded_r, seeded_nxt;
  logic [IW-1:0]       fill_r, fill_nxt;
  logic [IW-1:0]       lv_r, lv_nxt;
  logic [IW-1:0]       emit_r, emit_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [SAMPLE_W-1:0] buf_r [LOOKAHEAD];
  logic [SAMPLE_W-1:0] buf_nxt [LOOKAHEAD];
  a4la_dec_t           stk_r [LOOKAHEAD];
  a4la_dec_t           stk_nxt [LOOKAHEAD];
  logic [CBW-1:0]      combo_r, combo_nxt;
  logic [CBW-1:0]      best_r, best_nxt;
  logic [ERR_W-1:0]    best_err_r, best_err_nxt;
  logic [SAMPLE_W-1:0] out_value_r, out_value_nxt;
  logic                out_is_raw_r, out_is_raw_nxt;
  logic [ERR_W-1:0]    out_err_r, out_err_nxt;
  logic                out_last_r, out_last_nxt;

  logic [CODE_W-1:0]   cdig [LOOKAHEAD];
  logic [CODE_W-1:0]   bdig [LOOKAHEAD];
  logic [IW-1:0]       carry_lv;
  logic                out_free;

  a4la_dec_t           node_cur;
  a4la_dec_t           node_nxt;
  logic [CODE_W-1:0]   node_code;
  logic [SAMPLE_W-1:0] node_target;

  // split candidate and best code words into digits, first code on top
  always_comb begin
    for (int k = 0; k < LOOKAHEAD; k++) begin
      cdig[k] = combo_r[CODE_W*(LOOKAHEAD-1-k) +: CODE_W];
      bdig[k] = best_r[CODE_W*(LOOKAHEAD-1-k) +: CODE_W];
    end
  end

  // deepest level whose digit still counts up; search resumes there
  always_comb begin
    carry_lv = '0;
    for (int k = 0; k < LOOKAHEAD; k++) begin
      if (cdig[k] != CODE_MAX) begin
        carry_lv = IW'(k);
      end
    end
  end

  // operand select for the shared decoder unit
  always_comb begin
    if (state_r == ST_EMIT) begin
      node_cur.pred = pred_r;
      node_cur.step = step_r;
      node_cur.err  = '0;
      node_code     = bdig[emit_r];
      node_target   = '0;
    end else begin
      node_cur    = stk_r[lv_r];
      node_code   = cdig[lv_r];
      node_target = buf_r[lv_r];
    end
  end

  a4la_node_unit u_node (
    .cur    (node_cur),
    .code   (node_code),
    .target (node_target),
    .nxt    (node_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    pred_nxt       = pred_r;
    step_nxt       = step_r;
    seeded_nxt     = seeded_r;
    fill_nxt       = fill_r;
    lv_nxt         = lv_r;
    emit_nxt       = emit_r;
    buf_nxt        = buf_r;
    stk_nxt        = stk_r;
    combo_nxt      = combo_r;
    best_nxt       = best_r;
    best_err_nxt   = best_err_r;
    out_value_nxt  = out_value_r;
    out_is_raw_nxt = out_is_raw_r;
    out_err_nxt    = out_err_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_first) begin
            // new stream: reseed and drop any partial group
            pred_nxt   = in_sample;
            step_nxt   = STEP_RESET;
            fill_nxt   = '0;
            seeded_nxt = 1'b1;
            state_nxt  = ST_RAW;
          end else if (seeded_r) begin
            buf_nxt[fill_r] = in_sample;
            if (fill_r == LV_LAST) begin
              fill_nxt        = '0;
              stk_nxt[0].pred = pred_r;
              stk_nxt[0].step = step_r;
              stk_nxt[0].err  = '0;
              lv_nxt          = '0;
              combo_nxt       = '0;
              best_err_nxt    = '1;
              state_nxt       = ST_SEARCH;
            end else begin
              fill_nxt = fill_r + IW'(1);
            end
          end
        end
      end

      ST_RAW: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = pred_r;
          out_is_raw_nxt = 1'b1;
          out_err_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      ST_SEARCH: begin
        if (lv_r != LV_LAST) begin
          // inner node: push state one level down
          stk_nxt[lv_r + IW'(1)] = node_nxt;
          lv_nxt                 = lv_r + IW'(1);
        end else begin
          // leaf: keep the first sequence with the least error
          if (node_nxt.err < best_err_r) begin
            best_err_nxt = node_nxt.err;
            best_nxt     = combo_r;
          end
          if (&combo_r) begin
            emit_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            combo_nxt = combo_r + CBW'(1);
            lv_nxt    = carry_lv;
          end
        end
      end

      ST_EMIT: begin
        // replay chosen codes through the decoder unit
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = {4'b0, bdig[emit_r]};
          out_is_raw_nxt = 1'b0;
          out_err_nxt    = best_err_r;
          out_last_nxt   = (emit_r == LV_LAST);
          pred_nxt       = node_nxt.pred;
          step_nxt       = node_nxt.step;
          if (emit_r == LV_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_nxt = emit_r + IW'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pred_r      <= '0;
      step_r      <= STEP_RESET;
      seeded_r    <= 1'b0;
      fill_r      <= '0;
      lv_r        <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pred_r      <= pred_nxt;
      step_r      <= step_nxt;
      seeded_r    <= seeded_nxt;
      fill_r      <= fill_nxt;
      lv_r        <= lv_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    buf_r        <= buf_nxt;
    stk_r        <= stk_nxt;
    combo_r      <= combo_nxt;
    best_r       <= best_nxt;
    best_err_r   <= best_err_nxt;
    out_value_r  <= out_value_nxt;
    out_is_raw_r <= out_is_raw_nxt;
    out_err_r    <= out_err_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_is_raw      = out_is_raw_r;
  assign out_group_error = out_err_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // step only ever takes the values 1, 2, 4 or 8
  a_step_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(step_r) && (step_r <= STEP_MAX))
    else $error("step size left its power-of-two range");

  // a raw seed is a single transfer with no error
  a_raw_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_raw |-> out_last && (out_group_error == '0))
    else $error("raw transfer without last or with nonzero error");

  // the search always finds a sequence before codes go out
  a_best_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (best_err_r != '1))
    else $error("emit started without a best sequence");

  // the search ends only after the last candidate
  a_search_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) && (state_nxt == ST_EMIT) |-> (&combo_r) && (lv_r == LV_LAST))
    else $error("search left before the last leaf");
`endif

endmodule
